// ===== src/lbs_pkg.sv =====
`default_nettype none
package lbs_pkg;

  localparam int LAYER_COUNT = 32;
  localparam int IDX_W       = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int TOK_W       = 32;
  localparam int BAT_W       = 16;
  // block sums never overflow: one extra bit per doubling of the layer count
  localparam int SUM_W       = TOK_W + IDX_W;
  localparam int MODE_W      = 2;
  localparam int GRP_W       = 6;
  localparam int CHOSEN_W    = 6;

  localparam logic [TOK_W-1:0]    TOK_MAX   = '1;
  localparam logic [BAT_W-1:0]    BAT_MAX   = '1;
  localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(LAYER_COUNT - 1);
  localparam logic [CHOSEN_W-1:0] NONE_CODE = '1;

  // policy codes
  localparam logic [MODE_W-1:0] MODE_FIRST   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TOKENS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLOCK   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BATCHES = 2'd3;

  // item actions
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_SCHED = 1'b1;

  // configuration register indexes
  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_GROUP  = 1'b1;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [TOK_W-1:0] tok;
    logic [BAT_W-1:0] bat;
  } store_wr_t;

  typedef struct packed {
    logic             start;  // clear accumulators before a scan
    logic             step;   // one layer's counts present
    logic             last;   // this is the last layer
    logic [IDX_W-1:0] idx;
  } eval_ctl_t;

endpackage
`default_nettype wire

// ===== src/lbs_store.sv =====
`default_nettype none
module lbs_store (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire lbs_pkg::store_wr_t        wr,
  input  wire [lbs_pkg::IDX_W-1:0]       rd_addr,
  output logic [lbs_pkg::TOK_W-1:0]      rd_tok,
  output logic [lbs_pkg::BAT_W-1:0]      rd_bat
);

  logic [lbs_pkg::TOK_W-1:0]       tok_mem [lbs_pkg::LAYER_COUNT];
  logic [lbs_pkg::BAT_W-1:0]       bat_mem [lbs_pkg::LAYER_COUNT];
  logic [lbs_pkg::LAYER_COUNT-1:0] vld_r;
  logic [lbs_pkg::TOK_W-1:0]       rd_tok_r;
  logic [lbs_pkg::BAT_W-1:0]       rd_bat_r;
  logic                            rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tok_mem[wr.addr] <= wr.tok;
      bat_mem[wr.addr] <= wr.bat;
    end
    rd_tok_r <= tok_mem[rd_addr];
    rd_bat_r <= bat_mem[rd_addr];
  end

  // an entry not yet written since reset reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
    end
  end

  assign rd_tok = rd_vld_r ? rd_tok_r : '0;
  assign rd_bat = rd_vld_r ? rd_bat_r : '0;

endmodule
`default_nettype wire

// ===== src/lbs_eval.sv =====
`default_nettype none
module lbs_eval (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire lbs_pkg::eval_ctl_t          ctl,
  input  wire [lbs_pkg::MODE_W-1:0]        mode,
  input  wire [lbs_pkg::GRP_W-1:0]         group_width,
  input  wire [lbs_pkg::TOK_W-1:0]         tok,
  input  wire [lbs_pkg::BAT_W-1:0]         bat,
  output logic                             res_found,
  output logic [lbs_pkg::IDX_W-1:0]        res_idx
);

  logic                       found_r, found_nxt;
  logic [lbs_pkg::IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [lbs_pkg::TOK_W-1:0]  best_tok_r, best_tok_nxt;
  logic [lbs_pkg::BAT_W-1:0]  best_bat_r, best_bat_nxt;
  logic [lbs_pkg::SUM_W-1:0]  best_sum_r, best_sum_nxt;
  logic [lbs_pkg::SUM_W-1:0]  blk_sum_r, blk_sum_nxt;
  logic [lbs_pkg::GRP_W-1:0]  blk_pos_r, blk_pos_nxt;
  logic                       blk_nz_v_r, blk_nz_v_nxt;
  logic [lbs_pkg::IDX_W-1:0]  blk_nz_idx_r, blk_nz_idx_nxt;

  logic                       tok_nz;
  logic [lbs_pkg::GRP_W-1:0]  w_eff;
  logic                       blk_end;
  logic [lbs_pkg::SUM_W-1:0]  blk_sum_cur;
  logic                       cur_nz_v;
  logic [lbs_pkg::IDX_W-1:0]  cur_nz_idx;
  logic                       take;

  assign tok_nz      = (tok != '0);
  assign w_eff       = (group_width == '0) ? lbs_pkg::GRP_W'(1) : group_width;
  assign blk_end     = (blk_pos_r == (w_eff - lbs_pkg::GRP_W'(1))) || ctl.last;
  assign blk_sum_cur = blk_sum_r + lbs_pkg::SUM_W'(tok);
  assign cur_nz_v    = blk_nz_v_r || tok_nz;
  assign cur_nz_idx  = blk_nz_v_r ? blk_nz_idx_r : ctl.idx;

  // the shared compare: which candidate beats the best so far
  always_comb begin
    case (mode)
      lbs_pkg::MODE_TOKENS:  take = (tok > best_tok_r);
      lbs_pkg::MODE_BLOCK:   take = blk_end && (blk_sum_cur > best_sum_r);
      lbs_pkg::MODE_BATCHES: take = (bat > best_bat_r) ||
                                    ((bat == best_bat_r) && (tok > best_tok_r));
      default:               take = tok_nz && !found_r;
    endcase
  end

  always_comb begin
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_tok_nxt   = best_tok_r;
    best_bat_nxt   = best_bat_r;
    best_sum_nxt   = best_sum_r;
    blk_sum_nxt    = blk_sum_r;
    blk_pos_nxt    = blk_pos_r;
    blk_nz_v_nxt   = blk_nz_v_r;
    blk_nz_idx_nxt = blk_nz_idx_r;
    if (ctl.start) begin
      found_nxt      = 1'b0;
      best_idx_nxt   = '0;
      best_tok_nxt   = '0;
      best_bat_nxt   = '0;
      best_sum_nxt   = '0;
      blk_sum_nxt    = '0;
      blk_pos_nxt    = '0;
      blk_nz_v_nxt   = 1'b0;
      blk_nz_idx_nxt = '0;
    end else if (ctl.step) begin
      if (take) begin
        found_nxt    = 1'b1;
        best_idx_nxt = (mode == lbs_pkg::MODE_BLOCK) ? cur_nz_idx : ctl.idx;
        best_tok_nxt = tok;
        best_bat_nxt = bat;
        best_sum_nxt = blk_sum_cur;
      end
      if (blk_end) begin
        blk_sum_nxt  = '0;
        blk_pos_nxt  = '0;
        blk_nz_v_nxt = 1'b0;
      end else begin
        blk_sum_nxt    = blk_sum_cur;
        blk_pos_nxt    = blk_pos_r + lbs_pkg::GRP_W'(1);
        blk_nz_v_nxt   = cur_nz_v;
        blk_nz_idx_nxt = cur_nz_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      blk_pos_r  <= '0;
      blk_nz_v_r <= 1'b0;
    end else begin
      found_r    <= found_nxt;
      blk_pos_r  <= blk_pos_nxt;
      blk_nz_v_r <= blk_nz_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r   <= best_idx_nxt;
    best_tok_r   <= best_tok_nxt;
    best_bat_r   <= best_bat_nxt;
    best_sum_r   <= best_sum_nxt;
    blk_sum_r    <= blk_sum_nxt;
    blk_nz_idx_r <= blk_nz_idx_nxt;
  end

  // most-tokens mode always answers, layer 0 when everything is empty
  assign res_found = (mode == lbs_pkg::MODE_TOKENS) ? 1'b1 : found_r;
  assign res_idx   = best_idx_r;

endmodule
`default_nettype wire

// ===== src/layer_batch_scheduler_core.sv =====
// Layer batch scheduler: per-layer pending token and batch counts.
// Input channel (in_valid/in_ready): in_action selects add or schedule.
//   Add: in_token_amount is added to layer in_target_layer (saturating) and
//   its batch count goes up by one (saturating). No item is returned.
//   Schedule: a layer is picked by the policy register, returned on the
//   result channel as out_chosen_layer (-1 when none qualifies), and both
//   of its counts are cleared.
// Config port: cfg_we/cfg_addr/cfg_wdata, index 0 policy, 1 group width.
//   Write only while the block is idle.
// Timing: one item at a time; in_ready is high only in idle.
//   An add reads, modifies and writes back the counter memory.
//   A schedule scans every layer: the counter memory has one read port, so
//   the scan reads one layer per cycle into the shared compare unit, then
//   the winner is cleared and the result registered.
// Stall: a result waits in the output register; a following schedule item
//   that finishes before it is taken holds in its last state until then.
// Reset: synchronous, active low; all counts read as zero afterwards
//   (per-entry valid bits, no clearing pass), policy 0, group width 1.
`default_nettype none
module layer_batch_scheduler_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_action,
  input  wire [4:0]                           in_target_layer,
  input  wire [15:0]                          in_token_amount,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [lbs_pkg::CHOSEN_W-1:0] out_chosen_layer,
  input  wire                                 cfg_we,
  input  wire                                 cfg_addr,
  input  wire [lbs_pkg::GRP_W-1:0]            cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD_RD = 3'd1;
  localparam logic [2:0] S_ADD_WR = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]                        state_r, state_nxt;
  logic [lbs_pkg::MODE_W-1:0]        policy_r;
  logic [lbs_pkg::GRP_W-1:0]         group_r;
  logic [lbs_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  logic [lbs_pkg::IDX_W-1:0]         tgt_r;
  logic                              tgt_ok_r;
  logic [15:0]                       amount_r;
  logic                              eval_v_r;
  logic                              eval_last_r;
  logic [lbs_pkg::IDX_W-1:0]         eval_idx_r;
  logic                              out_valid_r;
  logic [lbs_pkg::CHOSEN_W-1:0]      out_chosen_r;

  logic                              in_acc;
  logic                              out_free;
  logic [lbs_pkg::IDX_W-1:0]         rd_addr;
  logic [lbs_pkg::TOK_W-1:0]         rd_tok;
  logic [lbs_pkg::BAT_W-1:0]         rd_bat;
  logic [lbs_pkg::TOK_W:0]           tok_sum;
  lbs_pkg::store_wr_t                wr;
  lbs_pkg::eval_ctl_t                ctl;
  logic                              res_found;
  logic [lbs_pkg::IDX_W-1:0]         res_idx;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // ---------------- config registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= lbs_pkg::MODE_FIRST;
      group_r  <= lbs_pkg::GRP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lbs_pkg::CFG_POLICY: policy_r <= cfg_wdata[lbs_pkg::MODE_W-1:0];
        lbs_pkg::CFG_GROUP:  group_r  <= cfg_wdata;
        default:             ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt   = '0;
          state_nxt = (in_action == lbs_pkg::ACT_ADD) ? S_ADD_RD : S_SCAN;
        end
      end
      S_ADD_RD: state_nxt = S_ADD_WR;
      S_ADD_WR: state_nxt = S_IDLE;
      S_SCAN: begin
        idx_nxt = idx_r + lbs_pkg::IDX_W'(1);
        if (idx_r == lbs_pkg::LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_CLEAR;
      S_CLEAR: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      eval_v_r    <= 1'b0;
      eval_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      eval_v_r    <= (state_r == S_SCAN);
      eval_last_r <= (state_r == S_SCAN) && (idx_r == lbs_pkg::LAST_IDX);
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload and pipeline tags
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_r    <= lbs_pkg::IDX_W'(in_target_layer);
      tgt_ok_r <= (32'(in_target_layer) < lbs_pkg::LAYER_COUNT);
      amount_r <= in_token_amount;
    end
    eval_idx_r <= idx_r;
    if ((state_r == S_OUT) && out_free) begin
      out_chosen_r <= res_found ? lbs_pkg::CHOSEN_W'(res_idx) : lbs_pkg::NONE_CODE;
    end
  end

  // ---------------- counter memory ----------------
  assign rd_addr = (state_r == S_SCAN) ? idx_r : tgt_r;
  assign tok_sum = {1'b0, rd_tok} + (lbs_pkg::TOK_W + 1)'(amount_r);

  always_comb begin
    wr = '0;
    if (state_r == S_ADD_WR) begin
      wr.en   = tgt_ok_r;
      wr.addr = tgt_r;
      wr.tok  = tok_sum[lbs_pkg::TOK_W] ? lbs_pkg::TOK_MAX
                                        : tok_sum[lbs_pkg::TOK_W-1:0];
      wr.bat  = (rd_bat == lbs_pkg::BAT_MAX) ? rd_bat
                                             : rd_bat + lbs_pkg::BAT_W'(1);
    end else if (state_r == S_CLEAR) begin
      // winner's counts go back to zero
      wr.en   = res_found;
      wr.addr = res_idx;
    end
  end

  lbs_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_tok  (rd_tok),
    .rd_bat  (rd_bat)
  );

  // ---------------- shared compare unit ----------------
  always_comb begin
    ctl.start = in_acc && (in_action == lbs_pkg::ACT_SCHED);
    ctl.step  = eval_v_r;
    ctl.last  = eval_last_r;
    ctl.idx   = eval_idx_r;
  end

  lbs_eval u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .mode        (policy_r),
    .group_width (group_r),
    .tok         (rd_tok),
    .bat         (rd_bat),
    .res_found   (res_found),
    .res_idx     (res_idx)
  );

  assign out_valid        = out_valid_r;
  assign out_chosen_layer = out_chosen_r;

  // ---------------- assertions ----------------
  // counter memory is written only by the add path or the winner clear
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_ADD_WR) || (state_r == S_CLEAR))
    else $error("counter write outside add or clear");

  // the scan covers every layer before draining
  a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> ($past(idx_r) == lbs_pkg::LAST_IDX))
    else $error("scan ended early");

  // a new result only comes from the end of a schedule
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside schedule end");

  // a returned layer is either none or a real layer
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_chosen_r == lbs_pkg::NONE_CODE) ||
                    (32'(out_chosen_r) < lbs_pkg::LAYER_COUNT))
    else $error("result layer out of range");

endmodule
`default_nettype wire

// ===== tb/lbs_choice_checker.sv =====
`timescale 1ns / 100ps
// Watches both channels and the register port, keeps its own copy of the
// per-layer counters and predicts every scheduling decision.
module lbs_choice_checker (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  input  wire                                 in_ready,
  input  wire                                 in_action,
  input  wire [4:0]                           in_target_layer,
  input  wire [15:0]                          in_token_amount,
  input  wire                                 out_valid,
  input  wire                                 out_ready,
  input  wire signed [lbs_pkg::CHOSEN_W-1:0]  out_chosen_layer,
  input  wire                                 cfg_we,
  input  wire                                 cfg_addr,
  input  wire [lbs_pkg::GRP_W-1:0]            cfg_wdata,
  output int                                  mismatches,
  output int                                  awaiting,
  output int                                  decisions
);
  import lbs_pkg::*;

  logic [TOK_W-1:0]           tok_cnt [LAYER_COUNT];
  logic [BAT_W-1:0]           bat_cnt [LAYER_COUNT];
  logic [MODE_W-1:0]          policy;
  logic [GRP_W-1:0]           group_width;
  logic signed [CHOSEN_W-1:0] choice_q [$];
  logic signed [CHOSEN_W-1:0] want;
  logic [TOK_W:0]             tok_sum;
  int                         pick;
  int                         err_cnt;
  int                         done_cnt;

  // queue one predicted decision behind those already owed
  function automatic void note_choice(logic signed [CHOSEN_W-1:0] c);
    choice_q.insert(choice_q.size(), c);
  endfunction

  // lowest layer in [lo, hi) holding tokens, -1 if none
  function automatic int first_busy(int lo, int hi);
    int i;
    int found;
    found = -1;
    for (i = hi - 1; i >= lo; i--)
      if (tok_cnt[i] != '0) found = i;
    return found;
  endfunction

  function automatic int choose_layer();
    int i, j, w, start, stop, best;
    logic [SUM_W-1:0] sum, best_sum;
    logic [BAT_W-1:0] max_b;
    logic [TOK_W-1:0] max_t;
    best = -1;
    case (policy)
      MODE_TOKENS: begin
        best = 0;
        for (i = 0; i < LAYER_COUNT; i++)
          if (tok_cnt[i] > tok_cnt[best]) best = i;
      end
      MODE_BLOCK: begin
        w = (group_width == '0) ? 1 : int'(group_width);
        start = -1;
        best_sum = '0;
        for (i = 0; i < LAYER_COUNT; i += w) begin
          stop = (i + w < LAYER_COUNT) ? i + w : LAYER_COUNT;
          sum = '0;
          for (j = i; j < stop; j++) sum += tok_cnt[j];
          if (sum > best_sum) begin
            best_sum = sum;
            start = i;
          end
        end
        if (start >= 0)
          best = first_busy(start, (start + w < LAYER_COUNT) ? start + w : LAYER_COUNT);
      end
      MODE_BATCHES: begin
        max_b = '0;
        max_t = '0;
        for (i = 0; i < LAYER_COUNT; i++)
          if (bat_cnt[i] > max_b || (bat_cnt[i] == max_b && tok_cnt[i] > max_t)) begin
            best = i;
            max_b = bat_cnt[i];
            max_t = tok_cnt[i];
          end
      end
      default: best = first_busy(0, LAYER_COUNT);
    endcase
    return best;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAYER_COUNT; i++) begin
        tok_cnt[i] = '0;
        bat_cnt[i] = '0;
      end
      policy = MODE_FIRST;
      group_width = GRP_W'(1);
      choice_q.delete();
      err_cnt = 0;
      done_cnt = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_POLICY) policy = cfg_wdata[MODE_W-1:0];
        else group_width = cfg_wdata;
      end

      if (out_valid && out_ready) begin
        if (choice_q.size() == 0) begin
          $display("%0t: chosen_layer expected none, got %0d", $time, out_chosen_layer);
          err_cnt++;
        end else begin
          want = choice_q.pop_front();
          done_cnt++;
          if (out_chosen_layer !== want) begin
            $display("%0t: chosen_layer expected %0d, got %0d", $time, want,
                     out_chosen_layer);
            err_cnt++;
          end
        end
      end

      if (in_valid && in_ready) begin
        if (in_action == ACT_ADD) begin
          if (int'(in_target_layer) < LAYER_COUNT) begin
            tok_sum = tok_cnt[in_target_layer] + in_token_amount;
            tok_cnt[in_target_layer] = tok_sum[TOK_W] ? TOK_MAX : tok_sum[TOK_W-1:0];
            if (bat_cnt[in_target_layer] != BAT_MAX)
              bat_cnt[in_target_layer] = bat_cnt[in_target_layer] + 1'b1;
          end
        end else begin
          pick = choose_layer();
          if (pick >= 0 && pick < LAYER_COUNT) begin
            tok_cnt[pick] = '0;
            bat_cnt[pick] = '0;
            note_choice(CHOSEN_W'(pick));
          end else begin
            note_choice(NONE_CODE);
          end
        end
      end
    end
    mismatches <= err_cnt;
    awaiting   <= choice_q.size();
    decisions  <= done_cnt;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top level: clock, reset, stimulus and verdict. Prediction and comparison
// live in lbs_choice_checker, which hands back its mismatch count and the
// number of decisions still owed by the block.
module tb;
  import lbs_pkg::*;

  // no handshake of any kind for this long means the block has hung;
  // the slowest legal gap is a full scan plus a long receiver stall
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 118;
  // full-scale adds that make one layer clearly heavier than the rest
  localparam int FILL_ADDS   = 8;

  logic                       clk             = 1'b0;
  logic                       rst_n           = 1'b0;
  logic                       in_valid        = 1'b0;
  logic                       in_action       = 1'b0;
  logic [4:0]                 in_target_layer = '0;
  logic [15:0]                in_token_amount = '0;
  logic                       out_ready       = 1'b0;
  logic                       cfg_we          = 1'b0;
  logic                       cfg_addr        = 1'b0;
  logic [GRP_W-1:0]           cfg_wdata       = '0;
  wire                        in_ready;
  wire                        out_valid;
  wire signed [CHOSEN_W-1:0]  out_chosen_layer;

  int mismatches;
  int awaiting;
  int decisions;

  // per-cycle idle chance on each side, in percent
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int stall_cycles = 0;
  int n_add        = 0;
  int n_sched      = 0;
  int n_settings   = 0;

  logic [4:0]        hot_layers [4];
  logic [MODE_W-1:0] mode_list  [4] = '{MODE_FIRST, MODE_TOKENS, MODE_BLOCK, MODE_BATCHES};

  layer_batch_scheduler_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_target_layer  (in_target_layer),
    .in_token_amount  (in_token_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chosen_layer (out_chosen_layer),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  lbs_choice_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_target_layer  (in_target_layer),
    .in_token_amount  (in_token_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chosen_layer (out_chosen_layer),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .awaiting         (awaiting),
    .decisions        (decisions)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random back-pressure on the result channel
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: cycles with no item moving on any port
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, giving up", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one item, after a random gap, and hold it until taken.
  // Valid is only dropped when a gap is wanted, so back-to-back items
  // never see valid lowered and raised in the same step.
  task automatic send_item(input logic act, input logic [4:0] layer,
                           input logic [15:0] amount);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_target_layer <= layer;
    in_token_amount <= amount;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (act == ACT_ADD) n_add++;
    else n_sched++;
  endtask

  // target layer is ignored on a schedule item, so it carries noise
  task automatic ask_decision();
    send_item(ACT_SCHED, 5'($urandom), 16'($urandom));
  endtask

  // hold the sender off until every owed decision is out and the block idles
  task automatic wait_all_decisions();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0 || in_ready !== 1'b1);
  endtask

  // both registers, back to back, only with the block idle
  task automatic set_policy(input logic [MODE_W-1:0] mode, input logic [GRP_W-1:0] grp);
    wait_all_decisions();
    // an add leaves no result behind; give a late write-back time to land
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_POLICY;
    cfg_wdata <= GRP_W'(mode);
    @(posedge clk);
    cfg_addr  <= CFG_GROUP;
    cfg_wdata <= grp;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  // Random traffic: mostly adds, heavy on a few hot layers so counts build
  // up and ties appear; amounts lean to zero, full scale and tiny values.
  task automatic random_item();
    logic        act;
    logic [4:0]  layer;
    logic [15:0] amount;
    act   = ($urandom_range(99) < 35) ? ACT_SCHED : ACT_ADD;
    layer = ($urandom_range(1) == 1) ? hot_layers[$urandom_range(3)] : 5'($urandom);
    case ($urandom_range(9))
      0:          amount = '0;
      1:          amount = '1;
      2, 3, 4, 5: amount = 16'($urandom_range(8));
      default:    amount = 16'($urandom);
    endcase
    send_item(act, layer, amount);
  endtask

  initial begin
    int               ph;
    int               base;
    int               stride;
    logic [MODE_W-1:0] mode;
    logic [GRP_W-1:0]  grp;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 79;

    // --- directed ---
    // first non-empty: empty store, zero-token add (batch only), plain picks
    ask_decision();
    send_item(ACT_ADD, 5'd0, 16'd0);
    ask_decision();
    send_item(ACT_ADD, 5'd31, 16'hFFFF);
    send_item(ACT_ADD, 5'd7, 16'd1);
    ask_decision();
    ask_decision();

    // most tokens: all empty answers layer 0; a tie goes to the earlier layer
    set_policy(MODE_TOKENS, GRP_W'(1));
    ask_decision();
    send_item(ACT_ADD, 5'd3, 16'd500);
    send_item(ACT_ADD, 5'd9, 16'd500);
    ask_decision();
    ask_decision();
    ask_decision();

    // most batches: empty gives none, equal batches decided by tokens
    set_policy(MODE_BATCHES, GRP_W'(1));
    ask_decision();
    send_item(ACT_ADD, 5'd4, 16'd10);
    send_item(ACT_ADD, 5'd4, 16'd5);
    send_item(ACT_ADD, 5'd2, 16'd100);
    send_item(ACT_ADD, 5'd6, 16'd100);
    send_item(ACT_ADD, 5'd6, 16'd0);
    ask_decision();
    ask_decision();
    ask_decision();

    // block mode: zero width behaves as one, an oversized width is one block
    set_policy(MODE_BLOCK, GRP_W'(0));
    send_item(ACT_ADD, 5'd5, 16'd10);
    send_item(ACT_ADD, 5'd20, 16'd30);
    ask_decision();
    set_policy(MODE_BLOCK, '1);
    ask_decision();
    ask_decision();

    // --- random phases ---
    // three idling stages, each running every policy once
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph / 4)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      mode = mode_list[ph % 4];
      if (mode == MODE_BLOCK) begin
        case (ph / 4)
          0:       grp = GRP_W'(1);
          1:       grp = GRP_W'(32);
          default: grp = GRP_W'($urandom_range(2, 31));
        endcase
      end else begin
        grp = GRP_W'($urandom_range(0, 63));
      end
      set_policy(mode, grp);

      // hot layers: sometimes adjacent (shares a block), sometimes spread
      base   = $urandom_range(31);
      stride = $urandom_range(1, 8);
      for (int k = 0; k < 4; k++) hot_layers[k] = 5'(base + k * stride);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item();
        if ($urandom_range(99) < 2) wait_all_decisions();
      end
    end

    // --- heavy layers, no idling ---
    // Layer 1 takes a run of full-scale adds and layer 16 a shorter one, so
    // the two halves differ in width-16 block mode; the counts that remain
    // after each pick are then asked about by batches and by tokens.
    set_policy(MODE_BLOCK, GRP_W'(16));
    send_item(ACT_ADD, 5'd0, 16'd10);
    for (int n = 0; n < FILL_ADDS; n++) send_item(ACT_ADD, 5'd1, '1);
    for (int n = 0; n < 4; n++) send_item(ACT_ADD, 5'd16, '1);
    ask_decision();
    set_policy(MODE_BATCHES, GRP_W'(16));
    ask_decision();
    set_policy(MODE_TOKENS, GRP_W'(16));
    ask_decision();
    ask_decision();

    wait_all_decisions();
    // a stray late result would show within one scan time
    repeat (40) @(posedge clk);

    $display("Run: %0d adds, %0d schedule requests, %0d register settings,",
             n_add, n_sched, n_settings);
    $display("Run: %0d decisions checked over all four policies, group widths 0 to 63, "
             , decisions, "empty and tied layers and full-scale token adds");
    if (mismatches == 0 && awaiting == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
